// File: hdl/bsp_pkg.sv
// Shared types and constants for the byte to 17-bit slot packer.
package bsp_pkg;

  localparam int unsigned SLOT_BITS         = 17;
  localparam int unsigned BYTE_BITS         = 8;
  localparam int unsigned PEND_BITS         = 16;
  localparam int unsigned ACC_BITS          = PEND_BITS + BYTE_BITS;
  localparam int unsigned MAX_SLOTS         = 64;
  localparam int unsigned MAX_PAYLOAD_BYTES = 136;

  // Item kinds on the byte channel.
  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_PAYLOAD_BYTES = 1'b0;
  localparam logic CFG_SLOT_COUNT    = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } byte_item_t;

  typedef struct packed {
    logic [16:0] slot_value;
    logic [5:0]  slot_pos;
    logic        last_slot;
  } slot_item_t;

endpackage

// File: hdl/bsp_out_reg.sv
// Output register for the slot channel: holds one slot beat until it is taken.
module bsp_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  bsp_pkg::slot_item_t din,
  output logic                free,
  output logic                slot_valid,
  input  logic                slot_stall,
  output bsp_pkg::slot_item_t slot_item
);
  import bsp_pkg::*;

  // A new beat may enter when the register is empty or its beat leaves now.
  assign free = !slot_valid || !slot_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (free) begin
      slot_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      slot_item <= din;
    end
  end

endmodule

// File: hdl/byte_to_17bit_slot_packer.sv
// Top level of the byte to 17-bit slot packer.
//
// Bytes of a record arrive on the byte channel (byte_valid, byte_stall,
// byte_item) and are packed least significant bit first into 17-bit slots,
// which leave on the slot channel (slot_valid, slot_stall, slot_item).
// A beat moves at a rising edge where valid is high and stall is low.
// A data byte is handled in the cycle it is accepted; a slot it completes
// appears at the output register in the next cycle. One byte beat can be
// accepted in every cycle while the output register can take a result,
// including the cycle in which the waiting slot beat is taken.
// An end-of-record beat starts a flush: the partial slot and then zero
// slots leave at one per cycle while the receiver does not stall, up to
// the slot count, the last one marked, and the record state is cleared in
// the cycle after the final slot. Byte beats are stalled for the whole flush.
// When the receiver stalls, the output register holds its beat and byte
// beats are stalled as well. Reset empties the output register, clears the
// record state and sets payload_bytes to 136 and slot_count to 64.
// Configuration is written through cfg_write, cfg_index and cfg_data.
module byte_to_17bit_slot_packer (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  bsp_pkg::byte_item_t byte_item,
  output logic                slot_valid,
  input  logic                slot_stall,
  output bsp_pkg::slot_item_t slot_item
);
  import bsp_pkg::*;

  // Configuration registers.
  logic [7:0] payload_bytes;
  logic [6:0] slot_count;

  // Record state.
  logic [15:0] pending_bits;
  logic [4:0]  pending_count;
  logic [6:0]  slots_emitted;
  logic [7:0]  bytes_taken;
  logic        flushing;

  logic [15:0] pending_bits_next;
  logic [4:0]  pending_count_next;
  logic [6:0]  slots_emitted_next;
  logic [7:0]  bytes_taken_next;
  logic        flushing_next;

  logic [7:0]  eff_payload;
  logic [6:0]  eff_slots;
  logic        out_free;
  logic        byte_accept;
  logic        room;
  logic        take;
  logic [23:0] acc;
  logic [4:0]  cnt_sum;
  logic        full;
  logic        emit;
  slot_item_t  emit_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_bytes <= 8'(MAX_PAYLOAD_BYTES);
      slot_count    <= 7'(MAX_SLOTS);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PAYLOAD_BYTES: payload_bytes <= cfg_data;
        CFG_SLOT_COUNT:    slot_count    <= cfg_data[6:0];
        default:           ;
      endcase
    end
  end

  // Out-of-range settings are clamped where they are used.
  always_comb begin
    if (payload_bytes == 8'd0) begin
      eff_payload = 8'd1;
    end else if (payload_bytes > 8'(MAX_PAYLOAD_BYTES)) begin
      eff_payload = 8'(MAX_PAYLOAD_BYTES);
    end else begin
      eff_payload = payload_bytes;
    end
    if (slot_count == 7'd0) begin
      eff_slots = 7'd1;
    end else if (slot_count > 7'(MAX_SLOTS)) begin
      eff_slots = 7'(MAX_SLOTS);
    end else begin
      eff_slots = slot_count;
    end
  end

  assign byte_stall  = flushing || !out_free;
  assign byte_accept = byte_valid && !byte_stall;
  assign room        = slots_emitted < eff_slots;
  assign take        = bytes_taken < eff_payload;

  // Append the byte above the pending bits; at most 24 bits are live.
  assign acc     = {8'd0, pending_bits} | (24'(byte_item.data_byte) << pending_count);
  assign cnt_sum = pending_count + 5'(BYTE_BITS);
  assign full    = cnt_sum >= 5'(SLOT_BITS);

  always_comb begin
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    slots_emitted_next = slots_emitted;
    bytes_taken_next   = bytes_taken;
    flushing_next      = flushing;
    emit               = 1'b0;
    emit_item.slot_value = acc[16:0];
    emit_item.slot_pos   = slots_emitted[5:0];
    emit_item.last_slot  = (slots_emitted + 7'd1) == eff_slots;

    if (flushing) begin
      // Pending bits go out first (zero above them), then zero slots.
      emit_item.slot_value = {1'b0, pending_bits};
      if (!room) begin
        pending_bits_next  = '0;
        pending_count_next = '0;
        slots_emitted_next = '0;
        bytes_taken_next   = '0;
        flushing_next      = 1'b0;
      end else if (out_free) begin
        emit               = 1'b1;
        slots_emitted_next = slots_emitted + 7'd1;
        pending_bits_next  = '0;
        pending_count_next = '0;
      end
    end else if (byte_accept) begin
      case (byte_item.action)
        ACT_END: begin
          flushing_next = 1'b1;
        end
        ACT_DATA: begin
          if (take) begin
            bytes_taken_next = bytes_taken + 8'd1;
            if (full) begin
              emit               = room;
              slots_emitted_next = room ? slots_emitted + 7'd1 : slots_emitted;
              pending_bits_next  = {9'd0, acc[23:17]};
              pending_count_next = cnt_sum - 5'(SLOT_BITS);
            end else begin
              pending_bits_next  = acc[15:0];
              pending_count_next = cnt_sum;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
      slots_emitted <= '0;
      bytes_taken   <= '0;
      flushing      <= 1'b0;
    end else begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
      slots_emitted <= slots_emitted_next;
      bytes_taken   <= bytes_taken_next;
      flushing      <= flushing_next;
    end
  end

  bsp_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (emit),
    .din        (emit_item),
    .free       (out_free),
    .slot_valid (slot_valid),
    .slot_stall (slot_stall),
    .slot_item  (slot_item)
  );

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the byte to 17-bit slot packer.
`timescale 1ns / 100ps

module testbench;
  import bsp_pkg::*;

  // Cycles allowed for the block to settle once the last expected slot has gone.
  // It covers the output register and the record clear after a flush.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 360;
  localparam int unsigned HOLD_CYCLES  = 250;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_index = CFG_PAYLOAD_BYTES;
  logic [7:0] cfg_data = 8'd0;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  byte_item_t byte_item = '0;
  logic       slot_valid;
  logic       slot_stall = 1'b0;
  slot_item_t slot_item;

  byte_to_17bit_slot_packer dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .slot_valid (slot_valid),
    .slot_stall (slot_stall),
    .slot_item  (slot_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Beats waiting to be offered, and slots the packer is expected to produce.
  byte_item_t byte_queue[$];
  slot_item_t slots_due[$];
  int unsigned error_count = 0;

  // When set, the matching side offers or accepts beats without any gaps.
  bit sender_steady = 1'b0;
  bit receiver_steady = 1'b0;

  // Each increment asks the slot receiver for one long hold-off.
  int unsigned hold_requests = 0;

  // Our own copy of the packer: configuration as written and record state.
  logic [7:0]  payload_reg = 8'd136;
  logic [6:0]  slot_reg = 7'd64;
  logic [15:0] held_bits = '0;
  int unsigned held_count = 0;
  int unsigned slots_done = 0;
  int unsigned bytes_kept = 0;

  // Registers outside their legal range are clamped when they are used.
  function automatic int unsigned slot_limit();
    if (slot_reg < 7'd1) return 1;
    if (slot_reg > 7'(MAX_SLOTS)) return MAX_SLOTS;
    return 32'(slot_reg);
  endfunction

  function automatic int unsigned byte_limit();
    if (payload_reg < 8'd1) return 1;
    if (payload_reg > 8'(MAX_PAYLOAD_BYTES)) return MAX_PAYLOAD_BYTES;
    return 32'(payload_reg);
  endfunction

  // A slot beyond the slot count is simply lost.
  task automatic add_slot(input logic [16:0] value);
    slot_item_t s;
    if (slots_done < slot_limit()) begin
      s.slot_value = value;
      s.slot_pos   = 6'(slots_done);
      s.last_slot  = (slots_done + 1 == slot_limit());
      slots_due = {slots_due, s};
      slots_done++;
    end
  endtask

  task automatic predict_slots(input byte_item_t it);
    logic [23:0] acc;
    if (it.action == ACT_DATA) begin
      // Bytes past the payload length leave the record untouched.
      if (bytes_kept < byte_limit()) begin
        bytes_kept++;
        acc = {8'd0, held_bits} | (24'(it.data_byte) << held_count);
        held_count += BYTE_BITS;
        if (held_count >= SLOT_BITS) begin
          add_slot(acc[16:0]);
          acc = acc >> SLOT_BITS;
          held_count -= SLOT_BITS;
        end
        held_bits = acc[15:0];
      end
    end else begin
      // End of record: flush the partial slot, then pad with zero slots.
      if (held_count > 0)
        add_slot({1'b0, held_bits});
      while (slots_done < slot_limit())
        add_slot('0);
      held_bits  = '0;
      held_count = 0;
      slots_done = 0;
      bytes_kept = 0;
    end
  endtask

  // Byte sender. The front of the queue stays in place until its beat is
  // taken, so an empty queue means every beat has been accepted and predicted.
  int unsigned send_wait = 0;

  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      send_wait = 0;
    end else if (!(byte_valid && byte_stall)) begin
      if (byte_valid) begin
        predict_slots(byte_item);
        void'(byte_queue.pop_front());
        send_wait = sender_steady ? 0 : $urandom_range(0, 4);
      end
      if (send_wait > 0) begin
        send_wait--;
        byte_valid <= 1'b0;
      end else if (byte_queue.size() != 0) begin
        byte_item  <= byte_queue[0];
        byte_valid <= 1'b1;
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // Slot receiver: checks each beat against the oldest expectation and
  // draws its own stall pattern, with the occasional long hold-off.
  int unsigned recv_wait = 0;
  int unsigned hold_left = 0;
  int unsigned hold_served = 0;
  slot_item_t want;

  always @(posedge clk) begin
    if (rst) begin
      slot_stall <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (slot_valid && !slot_stall) begin
        if (slots_due.size() == 0) begin
          $error("unexpected slot: slot_value %05h slot_pos %0d last_slot %0b",
                 slot_item.slot_value, slot_item.slot_pos, slot_item.last_slot);
          error_count++;
        end else begin
          want = slots_due.pop_front();
          if (slot_item.slot_value !== want.slot_value) begin
            $error("slot_value: expected %05h, got %05h", want.slot_value,
                   slot_item.slot_value);
            error_count++;
          end
          if (slot_item.slot_pos !== want.slot_pos) begin
            $error("slot_pos: expected %0d, got %0d", want.slot_pos,
                   slot_item.slot_pos);
            error_count++;
          end
          if (slot_item.last_slot !== want.last_slot) begin
            $error("last_slot: expected %0b, got %0b", want.last_slot,
                   slot_item.last_slot);
            error_count++;
          end
        end
        recv_wait = receiver_steady ? 0 : $urandom_range(0, 4);
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        slot_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        slot_stall <= 1'b1;
      end else begin
        slot_stall <= 1'b0;
      end
    end
  end

  // Register writes happen only while the packer is idle, so the model
  // copy can be updated as soon as the write is driven.
  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == CFG_PAYLOAD_BYTES)
      payload_reg = value;
    else
      slot_reg = value[6:0];
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] value);
    byte_item_t it;
    it.action    = ACT_DATA;
    it.data_byte = value;
    byte_queue = {byte_queue, it};
  endtask

  // The byte field of an end-of-record beat is ignored, so it carries noise.
  task automatic push_end();
    byte_item_t it;
    it.action    = ACT_END;
    it.data_byte = 8'($urandom_range(0, 255));
    byte_queue = {byte_queue, it};
  endtask

  task automatic wait_idle();
    while (byte_queue.size() != 0 || slots_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  int unsigned random_items = 0;

  task automatic queue_record(input int unsigned nbytes, input bit closed);
    repeat (nbytes) push_byte(8'($urandom_range(0, 255)));
    random_items += nbytes;
    if (closed) begin
      push_end();
      random_items++;
    end
  endtask

  logic [7:0] pick;

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: a record whose bytes hit both extremes, two slots filled
    // by data alone and a partial slot flushed, then an empty record.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hA5);
    push_byte(8'h5A);
    push_byte(8'hFF);
    push_end();
    push_end();
    wait_idle();

    // Three bytes kept per record; the extra bytes are dropped.
    write_reg(CFG_PAYLOAD_BYTES, 8'd3);
    write_reg(CFG_SLOT_COUNT, 8'd2);
    repeat (5) push_byte(8'($urandom_range(0, 255)));
    push_end();
    wait_idle();

    // One slot per record: data completes the final slot, later slots
    // overflow and the end of record has nothing left to send.
    write_reg(CFG_PAYLOAD_BYTES, 8'd136);
    write_reg(CFG_SLOT_COUNT, 8'd1);
    repeat (7) push_byte(8'($urandom_range(0, 255)));
    push_end();
    wait_idle();

    // Zero in both registers clamps to one.
    write_reg(CFG_PAYLOAD_BYTES, 8'd0);
    write_reg(CFG_SLOT_COUNT, 8'd0);
    push_byte(8'hC3);
    push_byte(8'h3C);
    push_end();
    wait_idle();

    // Back-pressure: the receiver holds off for a long stretch while the
    // sender keeps offering, so the packer fills up and stalls its input.
    write_reg(CFG_PAYLOAD_BYTES, 8'd136);
    write_reg(CFG_SLOT_COUNT, 8'd64);
    sender_steady = 1'b1;
    receiver_steady = 1'b0;
    hold_requests++;
    queue_record(60, 1'b1);
    wait_idle();

    // Random phases. A phase may stop in the middle of a record, in which
    // case the next settings take effect part-way through it.
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       pick = 8'd1;
        1:       pick = 8'd136;
        2:       pick = 8'd0;
        3:       pick = 8'($urandom_range(137, 255));
        default: pick = 8'($urandom_range(1, 136));
      endcase
      write_reg(CFG_PAYLOAD_BYTES, pick);
      case ($urandom_range(0, 5))
        0:       pick = 8'd1;
        1:       pick = 8'd64;
        2:       pick = 8'd0;
        3:       pick = 8'($urandom_range(65, 127));
        default: pick = 8'($urandom_range(1, 64));
      endcase
      write_reg(CFG_SLOT_COUNT, pick);
      sender_steady   = ($urandom_range(0, 3) == 0);
      receiver_steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) begin
        // Mostly short records, now and then a long one that can run past the longest payload.
        if ($urandom_range(0, 7) == 0)
          queue_record($urandom_range(0, 150), ($urandom_range(0, 3) != 0));
        else
          queue_record($urandom_range(0, 24), ($urandom_range(0, 3) != 0));
      end
      wait_idle();
    end

    // Close any record left open so that its padding is checked too.
    push_end();
    wait_idle();

    if (error_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
